// File: design/ntc_pkg.sv
package ntc_pkg;

    // Converter and configuration widths.
    localparam int ADC_BITS  = 12;
    localparam int PULLUP_W  = 16;
    localparam int THRESH_W  = 12;
    localparam int RES_W     = 16;
    localparam int TEMP_W    = 7;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // Divider layout: the product is ADC_BITS + PULLUP_W bits wide and the
    // quotient is kept to RES_W bits, with a separate saturation flag.
    localparam int NUM_W      = ADC_BITS + PULLUP_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = RES_W / DIV_STEPS;

    // Lookup table layout.
    localparam int RES_COUNT = 146;
    localparam int IDX_W     = 8;
    localparam int GROUP     = 16;
    localparam int GROUPS    = (RES_COUNT + GROUP - 1) / GROUP;
    localparam int GCNT_W    = 5;

    localparam logic [RES_W-1:0]  DEFAULT_RES  = 16'd3274;
    localparam logic [IDX_W-1:0]  INDEX_OFFSET = 8'd40;
    localparam logic [TEMP_W-1:0] TEMP_MAX     = 7'd100;

    localparam logic [PULLUP_W-1:0] PULLUP_RESET    = 16'd1000;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 12'd10;

    // Register indexes on the configuration port (word aligned).
    typedef enum logic {
        REG_PULLUP    = 1'b0,
        REG_THRESHOLD = 1'b1
    } reg_idx_t;

    // Live configuration handed from the register block to the datapath.
    typedef struct packed {
        logic [PULLUP_W-1:0] pullup_res;
        logic [THRESH_W-1:0] threshold;
    } cfg_t;

    // Special cases that override the divider result.
    typedef struct packed {
        logic force_default;
        logic force_zero;
    } res_tag_t;

    // Thermistor resistance per degree, index 0 standing for -40 degrees.
    localparam logic [RES_W-1:0] RES_TABLE [RES_COUNT] = '{
        16'd34092, 16'd31887, 16'd29839, 16'd27936, 16'd26167, 16'd24522, 16'd22990,
        16'd21564, 16'd20236, 16'd18998, 16'd17844, 16'd16767, 16'd15762, 16'd14824,
        16'd13948, 16'd13128, 16'd12362, 16'd11646, 16'd10976, 16'd10348, 16'd9760,
        16'd9209,  16'd8693,  16'd8208,  16'd7754,  16'd7327,  16'd6927,  16'd6551,
        16'd6198,  16'd5865,  16'd5553,  16'd5259,  16'd4982,  16'd4722,  16'd4477,
        16'd4246,  16'd4028,  16'd3823,  16'd3629,  16'd3446,  16'd3274,  16'd3111,
        16'd2957,  16'd2812,  16'd2674,  16'd2545,  16'd2422,  16'd2306,  16'd2196,
        16'd2092,  16'd1993,  16'd1900,  16'd1811,  16'd1728,  16'd1648,  16'd1573,
        16'd1501,  16'd1433,  16'd1369,  16'd1308,  16'd1250,  16'd1194,  16'd1142,
        16'd1092,  16'd1045,  16'd1000,  16'd957,   16'd916,   16'd877,   16'd840,
        16'd805,   16'd771,   16'd739,   16'd709,   16'd679,   16'd652,   16'd625,
        16'd600,   16'd576,   16'd553,   16'd531,   16'd510,   16'd490,   16'd471,
        16'd453,   16'd435,   16'd418,   16'd402,   16'd387,   16'd372,   16'd358,
        16'd345,   16'd332,   16'd320,   16'd308,   16'd297,   16'd286,   16'd276,
        16'd266,   16'd256,   16'd247,   16'd238,   16'd230,   16'd222,   16'd214,
        16'd207,   16'd199,   16'd193,   16'd186,   16'd180,   16'd174,   16'd168,
        16'd162,   16'd157,   16'd152,   16'd147,   16'd142,   16'd137,   16'd133,
        16'd128,   16'd124,   16'd120,   16'd116,   16'd113,   16'd109,   16'd106,
        16'd102,   16'd99,    16'd96,    16'd93,    16'd90,    16'd88,    16'd85,
        16'd82,    16'd80,    16'd78,    16'd75,    16'd73,    16'd71,    16'd69,
        16'd67,    16'd65,    16'd63,    16'd61,    16'd59,    16'd58
    };

endpackage

// File: design/ntc_apb_regs.sv
module ntc_apb_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ntc_pkg::ADDR_W-1:0] paddr,
    input  logic [ntc_pkg::DATA_W-1:0] pwdata,
    output logic [ntc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output ntc_pkg::cfg_t             cfg
);
    import ntc_pkg::*;

    logic [PULLUP_W-1:0] pullup_reg;
    logic [PULLUP_W-1:0] pullup_next;
    logic [THRESH_W-1:0] threshold_reg;
    logic [THRESH_W-1:0] threshold_next;
    logic                wr_en;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);

    // Write decode: each register takes the low bits of the write data.
    always_comb
    begin
        pullup_next    = pullup_reg;
        threshold_next = threshold_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PULLUP:    pullup_next    = pwdata[PULLUP_W-1:0];
                REG_THRESHOLD: threshold_next = pwdata[THRESH_W-1:0];
                default:       pullup_next    = pullup_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullup_reg    <= PULLUP_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            pullup_reg    <= pullup_next;
            threshold_reg <= threshold_next;
        end
    end

    // Read-back of the register selected by the address.
    always_comb
    begin
        unique case (reg_idx)
            REG_PULLUP:    prdata = DATA_W'(pullup_reg);
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.pullup_res = pullup_reg;
    assign cfg.threshold  = threshold_reg;

    // A completed write to the pull-up register shows up in the live configuration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_PULLUP) |=> (cfg.pullup_res == $past(pwdata[PULLUP_W-1:0])))
        else $error("pull-up register did not take the written value");

endmodule

// File: design/ntc_divider.sv
module ntc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  ntc_pkg::res_tag_t             in_tag,
    input  logic [ntc_pkg::ADC_BITS-1:0]  adc,
    input  logic [ntc_pkg::PULLUP_W-1:0]  pullup_res,
    input  logic [ntc_pkg::ADC_BITS-1:0]  divisor,
    output logic                          out_valid,
    output ntc_pkg::res_tag_t             out_tag,
    output logic [ntc_pkg::RES_W-1:0]     quotient,
    output logic                          overflow
);
    import ntc_pkg::*;

    // Multiply stage.
    logic                mul_valid_reg;
    res_tag_t            mul_tag_reg;
    logic [NUM_W-1:0]    prod_reg;
    logic [ADC_BITS-1:0] mul_dvs_reg;

    // Stage 0 holds the saturation check, stages 1..DIV_STAGES the quotient steps.
    logic                valid_reg [DIV_STAGES+1];
    res_tag_t            tag_reg   [DIV_STAGES+1];
    logic                ovf_reg   [DIV_STAGES+1];
    logic [ADC_BITS-1:0] dvs_reg   [DIV_STAGES+1];
    logic [NUM_W-1:0]    rem_reg   [DIV_STAGES+1];
    logic [RES_W-1:0]    q_reg     [DIV_STAGES+1];
    logic [NUM_W-1:0]    rem_next  [DIV_STAGES+1];
    logic [RES_W-1:0]    q_next    [DIV_STAGES+1];
    logic                ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_tag_reg <= in_tag;
        prod_reg    <= NUM_W'(adc) * NUM_W'(pullup_res);
        mul_dvs_reg <= divisor;
    end

    // The quotient exceeds RES_W bits exactly when the product reaches divisor << RES_W.
    assign ovf_next = (prod_reg >= {mul_dvs_reg, {RES_W{1'b0}}});

    // Restoring division, DIV_STEPS quotient bits per stage, most significant first.
    always_comb
    begin : p_div_next
        logic [NUM_W-1:0] rem_v;
        logic [NUM_W-1:0] shifted;
        logic [RES_W-1:0] q_v;
        rem_v       = '0;
        shifted     = '0;
        q_v         = '0;
        rem_next[0] = prod_reg;
        q_next[0]   = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_v = rem_reg[s];
            q_v   = q_reg[s];
            for (int t = 0; t < DIV_STEPS; t++)
            begin
                shifted = NUM_W'(dvs_reg[s]) << (RES_W - 1 - s * DIV_STEPS - t);
                if (rem_v >= shifted)
                begin
                    rem_v = rem_v - shifted;
                    q_v[RES_W - 1 - s * DIV_STEPS - t] = 1'b1;
                end
            end
            rem_next[s+1] = rem_v;
            q_next[s+1]   = q_v;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= mul_valid_reg;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= mul_tag_reg;
        ovf_reg[0] <= ovf_next;
        dvs_reg[0] <= mul_dvs_reg;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            tag_reg[s+1] <= tag_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            dvs_reg[s+1] <= dvs_reg[s];
        end
        for (int s = 0; s <= DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign out_tag   = tag_reg[DIV_STAGES];
    assign quotient  = q_reg[DIV_STAGES];
    assign overflow  = ovf_reg[DIV_STAGES];

    // Without saturation the final remainder must be below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DIV_STAGES] && !ovf_reg[DIV_STAGES])
            |-> (rem_reg[DIV_STAGES] < NUM_W'(dvs_reg[DIV_STAGES])))
        else $error("divider remainder not below divisor");

endmodule

// File: design/ntc_lookup.sv
module ntc_lookup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  ntc_pkg::res_tag_t           in_tag,
    input  logic [ntc_pkg::RES_W-1:0]   quotient,
    input  logic                        overflow,
    output logic                        done,
    output logic [ntc_pkg::TEMP_W-1:0]  temperature_c
);
    import ntc_pkg::*;

    logic                 r_valid;
    logic [RES_W-1:0]     r_sel;
    logic [RES_COUNT-1:0] ge_next;
    logic [RES_COUNT-1:0] ge_reg;
    logic                 ge_valid_reg;
    logic [GCNT_W-1:0]    gcnt_next [GROUPS];
    logic [GCNT_W-1:0]    gcnt_reg  [GROUPS];
    logic                 gcnt_valid_reg;
    logic [IDX_W-1:0]     total;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     temp_wide;
    logic [TEMP_W-1:0]    temp_next;
    logic                 done_reg;
    logic [TEMP_W-1:0]    temp_reg;

    assign r_valid = in_valid;

    // Resistance after the special cases, then one comparator per table entry.
    always_comb
    begin
        priority if (in_tag.force_default)
            r_sel = DEFAULT_RES;
        else if (in_tag.force_zero)
            r_sel = '0;
        else if (overflow)
            r_sel = '1;
        else
            r_sel = quotient;
        for (int j = 0; j < RES_COUNT; j++)
        begin
            ge_next[j] = (RES_TABLE[j] >= r_sel);
        end
    end

    // Count the set comparator bits in groups of GROUP entries.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            gcnt_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < RES_COUNT)
                begin
                    gcnt_next[g] = gcnt_next[g] + GCNT_W'(ge_reg[g * GROUP + k]);
                end
            end
        end
    end

    // The number of entries at or above the resistance, less one, is the table
    // index; then shift by the offset and clamp to the temperature range.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + IDX_W'(gcnt_reg[g]);
        end
        idx = (total == '0) ? '0 : total - 1'b1;
        if (idx < INDEX_OFFSET)
            temp_wide = '0;
        else
            temp_wide = idx - INDEX_OFFSET;
        if (temp_wide > IDX_W'(TEMP_MAX))
            temp_next = TEMP_MAX;
        else
            temp_next = temp_wide[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_valid_reg   <= 1'b0;
            gcnt_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            ge_valid_reg   <= r_valid;
            gcnt_valid_reg <= ge_valid_reg;
            done_reg       <= gcnt_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ge_reg   <= ge_next;
        gcnt_reg <= gcnt_next;
        temp_reg <= temp_next;
    end

    assign done          = done_reg;
    assign temperature_c = temp_reg;

    // The table descends, so the comparator bits form a thermometer code.
    assert property (@(posedge clk) disable iff (!rst_n)
        ge_valid_reg |-> ((ge_reg[RES_COUNT-1:1] & ~ge_reg[RES_COUNT-2:0]) == '0))
        else $error("comparator bits are not a thermometer code");

    // Every result lies in the clamped range.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (temp_reg <= TEMP_MAX))
        else $error("temperature result out of range");

endmodule

// File: design/ntc_adc_to_temperature_top.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// request   | start (busy always 0) | adc_sample[11:0]
// result    | done (one-cycle pulse)| temperature_c[6:0]
// config    | APB write/read        | paddr 0: pullup_scaled, 4: low_adc_threshold
//
// One request may be accepted in every cycle; busy stays low.
// done pulses when a request has passed through the input stage, the multiplier, the
// saturation check, eight two-bit divider stages and three lookup stages.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall; results leave in request order.
module ntc_adc_to_temperature_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ntc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ntc_pkg::DATA_W-1:0]   pwdata,
    output logic [ntc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [ntc_pkg::ADC_BITS-1:0] adc_sample,
    output logic                         done,
    output logic [ntc_pkg::TEMP_W-1:0]   temperature_c
);
    import ntc_pkg::*;

    cfg_t                cfg;
    logic                a_valid_reg;
    logic [ADC_BITS-1:0] a_adc_reg;
    logic [ADC_BITS-1:0] a_dvs_reg;
    res_tag_t            a_tag_reg;
    res_tag_t            a_tag_next;
    logic                div_valid;
    res_tag_t            div_tag;
    logic [RES_W-1:0]    div_quotient;
    logic                div_overflow;

    assign busy = 1'b0;

    ntc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage: flag the special cases and form the divisor.
    assign a_tag_next.force_default = (adc_sample <= cfg.threshold);
    assign a_tag_next.force_zero    = (adc_sample == ADC_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_adc_reg <= adc_sample;
        a_dvs_reg <= ADC_MAX - adc_sample;
        a_tag_reg <= a_tag_next;
    end

    ntc_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (a_valid_reg),
        .in_tag     (a_tag_reg),
        .adc        (a_adc_reg),
        .pullup_res (cfg.pullup_res),
        .divisor    (a_dvs_reg),
        .out_valid  (div_valid),
        .out_tag    (div_tag),
        .quotient   (div_quotient),
        .overflow   (div_overflow)
    );

    ntc_lookup u_lookup (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (div_valid),
        .in_tag        (div_tag),
        .quotient      (div_quotient),
        .overflow      (div_overflow),
        .done          (done),
        .temperature_c (temperature_c)
    );

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int PIPE_LATENCY  = 14;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 90;

    localparam bit [11:0] FULL_SCALE  = 12'hFFF;
    localparam bit [15:0] FIXED_OHMS  = 16'd3274;
    localparam bit [15:0] OHMS_CEIL   = 16'hFFFF;
    localparam int        OHMS_COUNT  = 146;
    localparam int        ZERO_DEG_AT = 40;
    localparam int        TOP_DEG     = 100;

    // Thermistor resistance for each degree, from -40 upwards.
    localparam bit [15:0] OHMS_PER_DEG [OHMS_COUNT] = '{
        16'd34092, 16'd31887, 16'd29839, 16'd27936, 16'd26167, 16'd24522, 16'd22990,
        16'd21564, 16'd20236, 16'd18998, 16'd17844, 16'd16767, 16'd15762, 16'd14824,
        16'd13948, 16'd13128, 16'd12362, 16'd11646, 16'd10976, 16'd10348, 16'd9760,
        16'd9209,  16'd8693,  16'd8208,  16'd7754,  16'd7327,  16'd6927,  16'd6551,
        16'd6198,  16'd5865,  16'd5553,  16'd5259,  16'd4982,  16'd4722,  16'd4477,
        16'd4246,  16'd4028,  16'd3823,  16'd3629,  16'd3446,  16'd3274,  16'd3111,
        16'd2957,  16'd2812,  16'd2674,  16'd2545,  16'd2422,  16'd2306,  16'd2196,
        16'd2092,  16'd1993,  16'd1900,  16'd1811,  16'd1728,  16'd1648,  16'd1573,
        16'd1501,  16'd1433,  16'd1369,  16'd1308,  16'd1250,  16'd1194,  16'd1142,
        16'd1092,  16'd1045,  16'd1000,  16'd957,   16'd916,   16'd877,   16'd840,
        16'd805,   16'd771,   16'd739,   16'd709,   16'd679,   16'd652,   16'd625,
        16'd600,   16'd576,   16'd553,   16'd531,   16'd510,   16'd490,   16'd471,
        16'd453,   16'd435,   16'd418,   16'd402,   16'd387,   16'd372,   16'd358,
        16'd345,   16'd332,   16'd320,   16'd308,   16'd297,   16'd286,   16'd276,
        16'd266,   16'd256,   16'd247,   16'd238,   16'd230,   16'd222,   16'd214,
        16'd207,   16'd199,   16'd193,   16'd186,   16'd180,   16'd174,   16'd168,
        16'd162,   16'd157,   16'd152,   16'd147,   16'd142,   16'd137,   16'd133,
        16'd128,   16'd124,   16'd120,   16'd116,   16'd113,   16'd109,   16'd106,
        16'd102,   16'd99,    16'd96,    16'd93,    16'd90,    16'd88,    16'd85,
        16'd82,    16'd80,    16'd78,    16'd75,    16'd73,    16'd71,    16'd69,
        16'd67,    16'd65,    16'd63,    16'd61,    16'd59,    16'd58
    };

    // One directed row: the settings it needs, the sample and, where it is
    // obvious, the temperature it must give.
    typedef struct packed {
        bit [15:0] pullup_val;
        bit [11:0] thresh;
        bit [11:0] adc;
        bit        known;
        bit [6:0]  temp;
    } sample_row_t;

    localparam int DIRECTED_COUNT = 24;
    localparam sample_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{16'd1000,  12'd10,   12'd0,    1'b1, 7'd0},
        '{16'd1000,  12'd10,   12'd10,   1'b1, 7'd0},
        '{16'd1000,  12'd10,   12'd3,    1'b1, 7'd0},
        '{16'd1000,  12'd10,   12'd11,   1'b0, 7'd0},
        '{16'd1000,  12'd10,   12'd2048, 1'b0, 7'd0},
        '{16'd1000,  12'd10,   12'd4094, 1'b1, 7'd0},
        '{16'd1000,  12'd10,   12'd4095, 1'b1, 7'd100},
        '{16'd1000,  12'd10,   12'hAAA,  1'b0, 7'd0},
        '{16'd1000,  12'd10,   12'h555,  1'b0, 7'd0},
        '{16'd65535, 12'd0,    12'd0,    1'b1, 7'd0},
        '{16'd65535, 12'd0,    12'd1,    1'b0, 7'd0},
        '{16'd65535, 12'd0,    12'd2048, 1'b0, 7'd0},
        '{16'd65535, 12'd0,    12'd4095, 1'b1, 7'd100},
        '{16'd1,     12'd4095, 12'd4095, 1'b1, 7'd0},
        '{16'd1,     12'd4095, 12'd0,    1'b1, 7'd0},
        '{16'd1,     12'd4095, 12'd2000, 1'b1, 7'd0},
        '{16'd0,     12'd0,    12'd100,  1'b1, 7'd100},
        '{16'd0,     12'd0,    12'd4094, 1'b1, 7'd100},
        '{16'd0,     12'd0,    12'd0,    1'b1, 7'd0},
        '{16'd34092, 12'd2047, 12'd2048, 1'b0, 7'd0},
        '{16'd34092, 12'd2047, 12'd4094, 1'b0, 7'd0},
        '{16'd3274,  12'd10,   12'd2048, 1'b0, 7'd0},
        '{16'd3274,  12'd10,   12'd2047, 1'b0, 7'd0},
        '{16'd3274,  12'd10,   12'd3071, 1'b0, 7'd0}
    };

    typedef struct {
        bit [11:0] adc;
        bit [6:0]  temp;
    } reading_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ntc_pkg::ADDR_W-1:0]     paddr = '0;
    logic [ntc_pkg::DATA_W-1:0]     pwdata = '0;
    logic [ntc_pkg::DATA_W-1:0]     prdata;
    logic                           pready;
    logic                           start = 1'b0;
    logic                           busy;
    logic [ntc_pkg::ADC_BITS-1:0]   adc_sample = '0;
    logic                           done;
    logic [ntc_pkg::TEMP_W-1:0]     temperature_c;

    // Directed rows carry their own expectation alongside the request.
    bit        fixed_known = 1'b0;
    bit [6:0]  fixed_temp = '0;

    // Copy of the register contents, kept in step with the writes.
    bit [15:0] pullup_cfg = 16'd1000;
    bit [11:0] thresh_cfg = 12'd10;

    reading_t  pending_temps [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;

    ntc_adc_to_temperature_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .adc_sample    (adc_sample),
        .done          (done),
        .temperature_c (temperature_c)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Converts one sample into degrees with the given settings.
    function automatic bit [6:0] predict_temp(bit [11:0] adc, bit [15:0] pullup_val,
                                              bit [11:0] thresh);
        bit [15:0] ohms;
        bit [27:0] product;
        bit [27:0] quotient;
        int        idx;
        bit        found;
        if (adc <= thresh)
            ohms = FIXED_OHMS;
        else if (adc == FULL_SCALE)
            ohms = '0;
        else
        begin
            product  = 28'(adc) * 28'(pullup_val);
            quotient = product / 28'(FULL_SCALE - adc);
            ohms     = (quotient > 28'(OHMS_CEIL)) ? OHMS_CEIL : quotient[15:0];
        end
        idx   = OHMS_COUNT - 1;
        found = 1'b0;
        if (ohms > OHMS_PER_DEG[0])
        begin
            idx   = 0;
            found = 1'b1;
        end
        for (int i = 0; i < OHMS_COUNT - 1; i++)
        begin
            if (!found && ohms <= OHMS_PER_DEG[i] && ohms > OHMS_PER_DEG[i + 1])
            begin
                idx   = i;
                found = 1'b1;
            end
        end
        if (idx < ZERO_DEG_AT)
            idx = 0;
        else
            idx = idx - ZERO_DEG_AT;
        if (idx > TOP_DEG)
            idx = TOP_DEG;
        return 7'(idx);
    endfunction

    task automatic log_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected %0d, got %0d", what, want, got);
    endtask

    // Watches requests and results, and stops a run that has hung.
    always @(posedge clk)
    begin
        reading_t entry;
        reading_t oldest;
        if (rst_n)
        begin
            quiet_cycles++;
            if (start && !busy)
            begin
                entry.adc  = adc_sample;
                entry.temp = fixed_known ? fixed_temp
                                         : predict_temp(adc_sample, pullup_cfg, thresh_cfg);
                pending_temps.push_back(entry);
                quiet_cycles = 0;
            end
            if (done)
            begin
                quiet_cycles = 0;
                if (pending_temps.size() == 0)
                    log_mismatch("result with no request pending", 0, temperature_c);
                else
                begin
                    oldest = pending_temps.pop_front();
                    if (temperature_c !== oldest.temp)
                        log_mismatch($sformatf("temperature_c for adc %0d", oldest.adc),
                                     oldest.temp, temperature_c);
                end
            end
            if (psel && penable && pready)
                quiet_cycles = 0;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Holds a request up until the block takes it.
    task automatic send_sample(bit [11:0] adc, bit known, bit [6:0] temp);
        start       <= 1'b1;
        adc_sample  <= adc;
        fixed_known <= known;
        fixed_temp  <= temp;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Mostly back to back, now and then a short pause, rarely a long one.
    task automatic idle_gap(bit no_gaps);
        int roll;
        int cycles;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            cycles = 0;
        else if (roll < 90)
            cycles = $urandom_range(1, 3);
        else if (roll < 98)
            cycles = $urandom_range(4, 10);
        else
            cycles = $urandom_range(20, 40);
        if (cycles > 0)
        begin
            start      <= 1'b0;
            adc_sample <= 12'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits for the pipeline to empty before the settings are touched.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_reg(ntc_pkg::reg_idx_t idx, bit [31:0] value);
        bit [15:0] want;
        bit [15:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ntc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == ntc_pkg::REG_PULLUP)
            pullup_cfg = value[15:0];
        else
            thresh_cfg = value[11:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == ntc_pkg::REG_PULLUP)
        begin
            want = pullup_cfg;
            got  = prdata[15:0];
        end
        else
        begin
            want = 16'(thresh_cfg);
            got  = 16'(prdata[11:0]);
        end
        if (got !== want)
            log_mismatch($sformatf("read back of register %s", idx.name()), want, got);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(bit [15:0] pullup_val, bit [11:0] thresh);
        wait_idle();
        write_reg(ntc_pkg::REG_PULLUP, {16'($urandom), pullup_val});
        write_reg(ntc_pkg::REG_THRESHOLD, {20'($urandom), thresh});
    endtask

    // Random sample, leaning on the threshold, the low end, full scale and the
    // points where the resistance crosses a table entry.
    function automatic bit [11:0] pick_adc();
        int      mode;
        longint  target;
        longint  guess;
        mode = $urandom_range(0, 9);
        case (mode)
            6:       guess = longint'(thresh_cfg) + $urandom_range(0, 2) - 1;
            7:       guess = $urandom_range(4088, 4095);
            8:       guess = $urandom_range(0, 20);
            9:
            begin
                target = OHMS_PER_DEG[$urandom_range(0, OHMS_COUNT - 1)];
                guess  = (target * 4095) / (target + longint'(pullup_cfg));
                guess  = guess + $urandom_range(0, 2) - 1;
            end
            default: guess = $urandom_range(0, 4095);
        endcase
        if (guess < 0)
            guess = 0;
        if (guess > 4095)
            guess = 4095;
        return 12'(guess);
    endfunction

    initial
    begin
        sample_row_t row;
        bit [15:0]   pullup_val;
        bit [11:0]   thresh;
        bit          no_gaps;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the first ones run on the values loaded at reset.
        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.pullup_val != pullup_cfg || row.thresh != thresh_cfg)
                apply_settings(row.pullup_val, row.thresh);
            send_sample(row.adc, row.known, row.temp);
            idle_gap(1'b0);
        end

        // Random phases, each under its own settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pullup_val = 16'hFFFF;
                    thresh     = 12'd0;
                end
                1:
                begin
                    pullup_val = 16'd1;
                    thresh     = 12'($urandom_range(0, 40));
                end
                2:
                begin
                    pullup_val = 16'($urandom_range(1, 65535));
                    thresh     = 12'($urandom_range(0, 300));
                end
                3:
                begin
                    pullup_val = 16'($urandom_range(200, 5000));
                    thresh     = 12'($urandom_range(0, 64));
                end
                4:
                begin
                    pullup_val = 16'($urandom_range(1, 65535));
                    thresh     = 12'($urandom_range(0, 4095));
                end
                default:
                begin
                    pullup_val = 16'd1000;
                    thresh     = 12'd10;
                end
            endcase
            no_gaps = (phase == RANDOM_PHASES - 1);
            apply_settings(pullup_val, thresh);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_sample(pick_adc(), 1'b0, 7'd0);
                idle_gap(no_gaps);
            end
        end

        wait_idle();
        repeat (PIPE_LATENCY) @(posedge clk);
        if (pending_temps.size() != 0)
            log_mismatch("requests left without a result", 0, pending_temps.size());
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: files.f
design/ntc_pkg.sv
design/ntc_apb_regs.sv
design/ntc_divider.sv
design/ntc_lookup.sv
design/ntc_adc_to_temperature_top.sv
verif/tb.sv
